// ----- rtl/core/ffsa_pkg.sv -----
// shared types and constants for the first-fit segment allocator
package ffsa_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_POOL    = 3'd1;
    localparam logic [2:0] ST_TABLE   = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] REG_MIN_CHUNK = 2'd0;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 17;

    // one table entry
    typedef struct packed {
        logic [15:0] start;
        logic [16:0] length;
        logic        busy;
    } seg_t;

    // table edit broadcast to all cells
    typedef struct packed {
        logic        en;
        logic        do_write;  // overwrite entry at wpos
        logic [9:0]  wpos;
        seg_t        wdata;
        logic        do_ins;    // open slot at ipos: cells > ipos take left neighbor
        logic [9:0]  ipos;
        seg_t        idata;     // written into ipos
        logic        do_del;    // close slot at dpos: cells >= dpos take right neighbor
        logic [9:0]  dpos;
    } edit_t;

endpackage

// ----- rtl/core/ffsa_cell.sv -----
// one segment table entry with shift and overwrite capability
module ffsa_cell #(
    parameter int MY_IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ffsa_pkg::edit_t  edit,
    input  ffsa_pkg::seg_t   left,
    input  ffsa_pkg::seg_t   right,
    output ffsa_pkg::seg_t   seg
);

    logic           busy_reg;
    logic [15:0]    start_reg;
    logic [16:0]    length_reg;
    ffsa_pkg::seg_t seg_next;
    logic [9:0]     me;

    assign me = 10'(MY_IDX);

    always_comb
    begin
        seg_next = {start_reg, length_reg, busy_reg};
        if (edit.en)
        begin
            if (edit.do_ins)
            begin
                if (me == edit.ipos)
                    seg_next = edit.idata;
                else if (me > edit.ipos)
                    seg_next = left;
            end
            if (edit.do_del && me >= edit.dpos)
                seg_next = right;
            if (edit.do_write && me == edit.wpos)
                seg_next = edit.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= seg_next.busy;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= seg_next.start;
        length_reg <= seg_next.length;
    end

    assign seg = {start_reg, length_reg, busy_reg};

endmodule

// ----- rtl/core/first_fit_segment_allocator_top.sv -----
// top level of the first-fit segment allocator
// Each request walks the segment table one entry per cycle starting at entry 0 and stops at the
// first fitting or matching entry or at the table end. An allocate edits the table (a row of cells
// that shift by one toward either neighbor for insert and remove) in its last scan cycle; a free
// clears the busy mark in S_EDIT, then checks the next neighbor in S_NEXT and the previous one in
// S_PREV for a merge; S_DONE then sets the result valid. A new request is taken in the cycle after
// the previous result left.
module first_fit_segment_allocator_top #(
    parameter longint POOL_BYTES = 65536,
    parameter int MAX_SEGMENTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [16:0] request_size,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] granted_address,
    output logic [2:0]  status
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int TOP_RAW = $clog2(POOL_BYTES + 1);
    localparam int TOP_W = (TOP_RAW > 17) ? TOP_RAW : 17;
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_SEGMENTS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_EDIT  = 6'b000100,
        S_NEXT  = 6'b001000,
        S_PREV  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [16:0] min_chunk_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TOP_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic cmd_reg;
    logic [16:0] size_reg;
    logic [15:0] addr_reg;
    logic out_valid_reg, out_valid_next;
    logic [15:0] gaddr_reg, gaddr_next;
    logic [2:0] status_reg, status_next;

    ffsa_pkg::seg_t segs [MAX_SEGMENTS];
    ffsa_pkg::seg_t cur, nxt, prv;
    ffsa_pkg::edit_t edit;
    ffsa_pkg::seg_t blank;

    assign blank = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            ffsa_cell #(.MY_IDX(g)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .edit  (edit),
                .left  ((g == 0) ? blank : segs[(g == 0) ? 0 : g - 1]),
                .right ((g == MAX_SEGMENTS - 1) ? blank :
                        segs[(g == MAX_SEGMENTS - 1) ? g : g + 1]),
                .seg   (segs[g])
            );
        end
    endgenerate

    logic [IDX_W-1:0] ci, ni, pi;
    assign ci  = idx_reg[IDX_W-1:0];
    assign ni  = ci + IDX_W'(1);
    assign pi  = ci - IDX_W'(1);
    assign cur = segs[ci];
    assign nxt = segs[ni];
    assign prv = segs[pi];

    logic in_acc;
    assign pready   = 1'b1;
    assign prdata   = {15'd0, min_chunk_reg};
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign granted_address = gaddr_reg;
    assign status = status_reg;

    logic [16:0] chunk;
    logic [TOP_W:0] room;
    logic [CNT_W:0] need_cnt;
    logic [16:0] cur_end_lo;
    logic [17:0] cur_end;

    assign chunk = (min_chunk_reg > size_reg) ? min_chunk_reg : size_reg;
    assign room  = (TOP_W+1)'(POOL_BYTES) - {1'b0, top_reg};
    assign need_cnt = {1'b0, count_reg} + ((chunk > size_reg) ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    assign cur_end = {2'b0, cur.start} + {1'b0, cur.length};
    assign cur_end_lo = cur_end[16:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        top_next = top_reg;
        idx_next = idx_reg;
        out_valid_next = out_valid_reg;
        gaddr_next = gaddr_reg;
        status_next = status_reg;
        edit = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmd_reg == ffsa_pkg::CMD_ALLOC && size_reg == 17'd0)
                begin
                    status_next = ffsa_pkg::ST_ZERO;
                    gaddr_next = '0;
                    state_next = S_DONE;
                end
                else if (idx_reg >= count_reg)
                begin
                    if (cmd_reg == ffsa_pkg::CMD_FREE)
                    begin
                        status_next = ffsa_pkg::ST_MISSING;
                        gaddr_next = '0;
                        state_next = S_DONE;
                    end
                    else if ({{(TOP_W-16){1'b0}}, chunk} > room)
                    begin
                        status_next = ffsa_pkg::ST_POOL;
                        gaddr_next = '0;
                        state_next = S_DONE;
                    end
                    else if (need_cnt > {1'b0, MAXC})
                    begin
                        status_next = ffsa_pkg::ST_TABLE;
                        gaddr_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // carve at pool top, append, split
                        edit.en = 1'b1;
                        edit.do_write = 1'b1;
                        edit.wpos = 10'(count_reg);
                        edit.wdata.start = top_reg[15:0];
                        edit.wdata.length = size_reg;
                        edit.wdata.busy = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (chunk > size_reg)
                        begin
                            edit.do_ins = 1'b1;
                            edit.ipos = 10'(count_reg) + 10'd1;
                            edit.idata.start = top_reg[15:0] + size_reg[15:0];
                            edit.idata.length = chunk - size_reg;
                            edit.idata.busy = 1'b0;
                            count_next = count_reg + CNT_W'(2);
                        end
                        top_next = top_reg + TOP_W'(chunk);
                        status_next = ffsa_pkg::ST_OK;
                        gaddr_next = top_reg[15:0];
                        state_next = S_DONE;
                    end
                end
                else if (cmd_reg == ffsa_pkg::CMD_FREE)
                begin
                    if (cur.start == addr_reg)
                        state_next = S_EDIT;
                    else
                        idx_next = idx_reg + CNT_W'(1);
                end
                else if (!cur.busy && cur.length >= size_reg)
                begin
                    if (cur.length > size_reg && count_reg >= MAXC)
                    begin
                        status_next = ffsa_pkg::ST_TABLE;
                        gaddr_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        edit.en = 1'b1;
                        edit.do_write = 1'b1;
                        edit.wpos = 10'(ci);
                        edit.wdata.start = cur.start;
                        edit.wdata.length = size_reg;
                        edit.wdata.busy = 1'b1;
                        if (cur.length > size_reg)
                        begin
                            edit.do_ins = 1'b1;
                            edit.ipos = 10'(ci) + 10'd1;
                            edit.idata.start = cur.start + size_reg[15:0];
                            edit.idata.length = cur.length - size_reg;
                            edit.idata.busy = 1'b0;
                            count_next = count_reg + CNT_W'(1);
                        end
                        status_next = ffsa_pkg::ST_OK;
                        gaddr_next = cur.start;
                        state_next = S_DONE;
                    end
                end
                else
                    idx_next = idx_reg + CNT_W'(1);
            end
            S_EDIT:
            begin
                edit.en = 1'b1;
                edit.do_write = 1'b1;
                edit.wpos = 10'(ci);
                edit.wdata = cur;
                edit.wdata.busy = 1'b0;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (idx_reg + CNT_W'(1) < count_reg && !nxt.busy &&
                    cur_end_lo == {1'b0, nxt.start})
                begin
                    edit.en = 1'b1;
                    edit.do_write = 1'b1;
                    edit.wpos = 10'(ci);
                    edit.wdata = cur;
                    edit.wdata.length = cur.length + nxt.length;
                    edit.do_del = 1'b1;
                    edit.dpos = 10'(ci) + 10'd1;
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = S_PREV;
            end
            S_PREV:
            begin
                if (idx_reg != '0 && !prv.busy &&
                    ({1'b0, prv.start} + prv.length) == {1'b0, cur.start})
                begin
                    edit.en = 1'b1;
                    edit.do_write = 1'b1;
                    edit.wpos = 10'(pi);
                    edit.wdata = prv;
                    edit.wdata.length = prv.length + cur.length;
                    edit.do_del = 1'b1;
                    edit.dpos = 10'(ci);
                    count_next = count_reg - CNT_W'(1);
                end
                status_next = ffsa_pkg::ST_OK;
                gaddr_next = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            top_reg <= '0;
            out_valid_reg <= 1'b0;
            min_chunk_reg <= 17'd4096;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg <= top_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
            if (psel && penable && pwrite && paddr == ffsa_pkg::REG_MIN_CHUNK)
                min_chunk_reg <= pwdata[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        gaddr_reg <= gaddr_next;
        status_reg <= status_next;
        if (in_acc)
        begin
            cmd_reg <= command;
            size_reg <= request_size;
            addr_reg <= block_address;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC) else $error("segment count overflow");
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TOP_W'(POOL_BYTES)) else $error("pool top overflow");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> out_valid_reg) else $error("result lost");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall) else $error("request taken while busy");

endmodule
